### src/pir_pkg.sv
// ----------------------------------------------------------------------------
// pir_pkg
// Shared constants for the palette index to RGB generator.
// ----------------------------------------------------------------------------
package pir_pkg;

    localparam int INDEX_WIDTH_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int FIELD_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int ROLES_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_ROLES    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX_0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX_1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX_2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_2 = 3'd6;

    localparam logic [1:0] ROLE_HUE     = 2'd0;
    localparam logic [1:0] ROLE_SAT     = 2'd1;
    localparam logic [1:0] ROLE_BRI     = 2'd2;
    localparam logic [1:0] ROLE_ILLEGAL = 2'd3;

    localparam logic [ROLES_W-1:0] ROLES_RESET   = 6'd36;
    localparam logic [FIELD_W-1:0] RADIX_0_RESET = 16'd16;
    localparam logic [FIELD_W-1:0] RADIX_1_RESET = 16'd4;
    localparam logic [FIELD_W-1:0] RADIX_2_RESET = 16'd4;

endpackage

### src/palette_index_to_rgb_top.sv
// ----------------------------------------------------------------------------
// palette_index_to_rgb_top
// HSB palette entry generator: mixed-radix split of an index into hue,
// saturation and brightness, then RGB bytes.
// ----------------------------------------------------------------------------
// One item is taken every cycle (busy stays low). Each result appears on
// done for one cycle, after the three chained digit dividers and the
// fraction dividers, one bit per stage, then the value register and the
// pir_mix stages. The receiver cannot stall; results must be taken.
module palette_index_to_rgb_top
    import pir_pkg::*;
#(
    parameter int INDEX_WIDTH   = INDEX_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pir_pkg::FIELD_W-1:0]   palette_index,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pir_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pir_pkg::FIELD_W-1:0]   cfg_data,
    output logic                          done,
    output logic [7:0]                    red,
    output logic [7:0]                    green,
    output logic [7:0]                    blue,
    output logic                          format_error
);

    localparam int IW = INDEX_WIDTH;
    localparam int FB = FRACTION_BITS;
    localparam logic [FB:0] ONE = (FB+1)'(1) << FB;

    logic [ROLES_W-1:0] roles_reg;
    logic [FIELD_W-1:0] radix_reg  [3];
    logic [FIELD_W-1:0] offset_reg [3];

    logic [IW+FIELD_W-1:0] idx_ext;
    logic [IW-1:0]         rest;
    logic                  d1_v, d2_v, d3_v, f_v;
    logic [IW-1:0]         q0, q1;
    logic [FIELD_W-1:0]    dig0, dig1, dig2, dig0_b, dig0_c, dig1_c;
    logic [FB-1:0]         frac [3];
    logic [1:0]            role [3];
    logic [FB:0]           val  [3];
    logic [FB+FIELD_W-1:0] off_sh [3];
    logic [FB:0]           hue_next, sat_next, bri_next;
    logic                  r_v_reg;
    logic [FB:0]           hue_reg, sat_reg, bri_reg;
    logic                  bad;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roles_reg     <= ROLES_RESET;
            radix_reg[0]  <= RADIX_0_RESET;
            radix_reg[1]  <= RADIX_1_RESET;
            radix_reg[2]  <= RADIX_2_RESET;
            offset_reg[0] <= '0;
            offset_reg[1] <= '0;
            offset_reg[2] <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ROLES:    roles_reg     <= cfg_data[ROLES_W-1:0];
                CFG_RADIX_0:  radix_reg[0]  <= cfg_data;
                CFG_RADIX_1:  radix_reg[1]  <= cfg_data;
                CFG_RADIX_2:  radix_reg[2]  <= cfg_data;
                CFG_OFFSET_0: offset_reg[0] <= cfg_data;
                CFG_OFFSET_1: offset_reg[1] <= cfg_data;
                CFG_OFFSET_2: offset_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign idx_ext = {IW'(0), palette_index};
    assign rest    = idx_ext[IW-1:0];

    pir_div #(.NUM_W(IW), .DEN_W(FIELD_W), .SIDE_W(1)) u_div0 (
        .clk(clk), .rst_n(rst_n), .in_valid(start), .in_num(rest),
        .in_rem('0), .den(radix_reg[0]), .in_side(1'b0),
        .out_valid(d1_v), .out_quo(q0), .out_rem(dig0), .out_side()
    );

    pir_div #(.NUM_W(IW), .DEN_W(FIELD_W), .SIDE_W(FIELD_W)) u_div1 (
        .clk(clk), .rst_n(rst_n), .in_valid(d1_v), .in_num(q0),
        .in_rem('0), .den(radix_reg[1]), .in_side(dig0),
        .out_valid(d2_v), .out_quo(q1), .out_rem(dig1), .out_side(dig0_b)
    );

    pir_div #(.NUM_W(IW), .DEN_W(FIELD_W), .SIDE_W(2*FIELD_W)) u_div2 (
        .clk(clk), .rst_n(rst_n), .in_valid(d2_v), .in_num(q1),
        .in_rem('0), .den(radix_reg[2]), .in_side({dig1, dig0_b}),
        .out_valid(d3_v), .out_quo(), .out_rem(dig2),
        .out_side({dig1_c, dig0_c})
    );

    pir_div #(.NUM_W(FB), .DEN_W(FIELD_W), .SIDE_W(1)) u_frac0 (
        .clk(clk), .rst_n(rst_n), .in_valid(d3_v), .in_num('0),
        .in_rem(dig0_c), .den(radix_reg[0]), .in_side(1'b0),
        .out_valid(f_v), .out_quo(frac[0]), .out_rem(), .out_side()
    );

    pir_div #(.NUM_W(FB), .DEN_W(FIELD_W), .SIDE_W(1)) u_frac1 (
        .clk(clk), .rst_n(rst_n), .in_valid(d3_v), .in_num('0),
        .in_rem(dig1_c), .den(radix_reg[1]), .in_side(1'b0),
        .out_valid(), .out_quo(frac[1]), .out_rem(), .out_side()
    );

    pir_div #(.NUM_W(FB), .DEN_W(FIELD_W), .SIDE_W(1)) u_frac2 (
        .clk(clk), .rst_n(rst_n), .in_valid(d3_v), .in_num('0),
        .in_rem(dig2), .den(radix_reg[2]), .in_side(1'b0),
        .out_valid(), .out_quo(frac[2]), .out_rem(), .out_side()
    );

    always_comb
    begin
        bad      = 1'b0;
        hue_next = '0;
        sat_next = '0;
        bri_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            role[k]   = roles_reg[2*k +: 2];
            off_sh[k] = {offset_reg[k], FB'(0)};
            val[k]    = (FB+1)'(frac[k]) + (FB+1)'(off_sh[k][FB+FIELD_W-1:FIELD_W]);
            if (val[k] > ONE)
            begin
                val[k] = val[k] - ONE;
            end
            if (role[k] == ROLE_ILLEGAL || radix_reg[k] == '0)
            begin
                bad = 1'b1;
            end
            case (role[k])
                ROLE_HUE: hue_next = val[k];
                ROLE_SAT: sat_next = val[k];
                ROLE_BRI: bri_next = val[k];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_v_reg <= 1'b0;
        end
        else
        begin
            r_v_reg <= f_v;
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg <= hue_next;
        sat_reg <= sat_next;
        bri_reg <= bri_next;
    end

    pir_mix #(.FB(FB)) u_mix (
        .clk(clk), .rst_n(rst_n), .in_valid(r_v_reg),
        .hue(hue_reg), .sat(sat_reg), .bri(bri_reg), .bad(bad),
        .out_valid(done), .red(red), .green(green), .blue(blue),
        .format_error(format_error)
    );

endmodule

### src/pir_div.sv
// ----------------------------------------------------------------------------
// pir_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pir_div #(
    parameter int NUM_W  = 16,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_rem,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quo,
    output logic [DEN_W-1:0]  out_rem,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg [NUM_W];
    logic [NUM_W-1:0]  num_reg   [NUM_W];
    logic [DEN_W-1:0]  rem_reg   [NUM_W];
    logic [SIDE_W-1:0] side_reg  [NUM_W];

    genvar s;
    generate
        for (s = 0; s < NUM_W; s++) begin : g_stage
            logic              cur_v;
            logic [NUM_W-1:0]  cur_num;
            logic [DEN_W-1:0]  cur_rem;
            logic [SIDE_W-1:0] cur_side;
            logic [DEN_W:0]    trial;
            logic              ge;
            logic [NUM_W-1:0]  num_next;
            logic [DEN_W-1:0]  rem_next;

            if (s == 0) begin : g_first
                assign cur_v    = in_valid;
                assign cur_num  = in_num;
                assign cur_rem  = in_rem;
                assign cur_side = in_side;
            end else begin : g_rest
                assign cur_v    = valid_reg[s-1];
                assign cur_num  = num_reg[s-1];
                assign cur_rem  = rem_reg[s-1];
                assign cur_side = side_reg[s-1];
            end

            always_comb
            begin
                trial    = {cur_rem, cur_num[NUM_W-1]};
                ge       = trial >= {1'b0, den};
                rem_next = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
                num_next = {cur_num[NUM_W-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else
                begin
                    valid_reg[s] <= cur_v;
                end
            end

            always_ff @(posedge clk)
            begin
                num_reg[s]  <= num_next;
                rem_reg[s]  <= rem_next;
                side_reg[s] <= cur_side;
            end
        end
    endgenerate

    assign out_valid = valid_reg[NUM_W-1];
    assign out_quo   = num_reg[NUM_W-1];
    assign out_rem   = rem_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

### src/pir_mix.sv
// ----------------------------------------------------------------------------
// pir_mix
// Hue to weights, saturation and brightness mixing, byte conversion.
// Four register stages.
// ----------------------------------------------------------------------------
module pir_mix #(
    parameter int FB = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [FB:0] hue,
    input  logic [FB:0] sat,
    input  logic [FB:0] bri,
    input  logic        bad,
    output logic        out_valid,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        format_error
);

    localparam logic [FB+2:0] ONE3 = (FB+3)'(1) << FB;
    localparam logic [FB:0]   ONE  = (FB+1)'(1) << FB;

    logic [FB+2:0] h3;
    logic [FB:0]   wr_next, wg_next, wb_next;

    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic [FB:0]   w_reg [3];
    logic [FB:0]   sat1_reg, bri1_reg, bri2_reg;
    logic [FB:0]   p_reg [3];
    logic [FB+1:0] c_reg [3];
    logic [7:0]    byte_reg [3];
    logic          err_reg;

    logic [2*FB+1:0] prod_p [3];
    logic [2*FB+1:0] prod_q [3];
    logic [FB:0]     inv_bri;
    logic [FB+1:0]   c_next [3];
    logic [FB+9:0]   scaled [3];

    always_comb
    begin
        h3 = (FB+3)'(hue) + (FB+3)'({hue, 1'b0});
        if (h3 < ONE3)
        begin
            wr_next = FB'(0) + (ONE - h3[FB:0]);
            wg_next = h3[FB:0];
            wb_next = '0;
        end
        else if (h3 > (ONE3 << 1))
        begin
            wr_next = (FB+1)'(h3 - (ONE3 << 1));
            wg_next = '0;
            wb_next = (FB+1)'(ONE3 + (ONE3 << 1) - h3);
        end
        else
        begin
            wr_next = '0;
            wg_next = (FB+1)'((ONE3 << 1) - h3);
            wb_next = (FB+1)'(h3 - ONE3);
        end
    end

    assign inv_bri = ONE - bri2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_p[i] = (2*FB+2)'(w_reg[i]) * (2*FB+2)'(sat1_reg);
            prod_q[i] = (2*FB+2)'(p_reg[i]) * (2*FB+2)'(inv_bri);
            c_next[i] = (FB+2)'(bri2_reg) + (FB+2)'(prod_q[i][2*FB:FB]);
            scaled[i] = (((FB+10)'(c_reg[i]) + (FB+10)'(ONE)) << 8)
                      - ((FB+10)'(c_reg[i]) + (FB+10)'(ONE)) + (FB+10)'(ONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg[0] <= wr_next;
        w_reg[1] <= wg_next;
        w_reg[2] <= wb_next;
        sat1_reg <= sat;
        bri1_reg <= bri;
        bri2_reg <= bri1_reg;
        for (int i = 0; i < 3; i++)
        begin
            p_reg[i]    <= prod_p[i][2*FB:FB];
            c_reg[i]    <= c_next[i];
            byte_reg[i] <= bad ? 8'd0 : scaled[i][FB+8:FB+1];
        end
        err_reg <= bad;
    end

    assign out_valid    = v4_reg;
    assign red          = byte_reg[0];
    assign green        = byte_reg[1];
    assign blue         = byte_reg[2];
    assign format_error = err_reg;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the palette index to RGB generator. Drives palette
// indices through the start/busy port under many register settings (roles,
// radices, offsets, format errors) and checks each RGB result against an
// in-bench HSB color predictor, in order of issue.
// ----------------------------------------------------------------------------
module tb_top;
    import pir_pkg::*;

    localparam int LATENCY = 3 * INDEX_WIDTH_DEF + FRACTION_BITS_DEF + 5;
    localparam longint ONE = 64'd1 << FRACTION_BITS_DEF;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       format_error;
    } rgb_entry_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [FIELD_W-1:0]   palette_index;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FIELD_W-1:0]   cfg_data;
    logic                 done;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic                 format_error;

    logic [ROLES_W-1:0]   roles_q;
    logic [FIELD_W-1:0]   radix_q [3];
    logic [FIELD_W-1:0]   offset_q [3];

    rgb_entry_t expected_rgb [$];
    int n_errors;
    int n_items;
    int n_results;
    int n_cfg;
    bit allow_idle;

    palette_index_to_rgb_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .palette_index (palette_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .format_error  (format_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint channel_to_byte(longint chan);
        return (((chan + ONE) * 255 + ONE) >> (FRACTION_BITS_DEF + 1)) & 8'hFF;
    endfunction

    function automatic longint blend(longint w, longint sat, longint bri);
        longint p;
        p = (w * sat) >> FRACTION_BITS_DEF;
        return bri + ((p * (ONE - bri)) >> FRACTION_BITS_DEF);
    endfunction

    function automatic rgb_entry_t predict_rgb(logic [FIELD_W-1:0] idx);
        rgb_entry_t res;
        longint rest, rdx, dig, val, hue, sat, bri, h3, wr, wg, wb;
        longint role_val [4];
        logic [1:0] role;
        res = '0;
        rest = idx;
        role_val = '{0, 0, 0, 0};
        for (int k = 0; k < 3; k++)
        begin
            if (roles_q[2*k +: 2] == ROLE_ILLEGAL || radix_q[k] == 0)
                res.format_error = 1'b1;
        end
        if (res.format_error)
            return res;
        for (int k = 0; k < 3; k++)
        begin
            rdx = radix_q[k];
            dig = rest % rdx;
            val = (dig << FRACTION_BITS_DEF) / rdx
                + ((longint'(offset_q[k]) << FRACTION_BITS_DEF) >> 16);
            if (val > ONE)
                val -= ONE;
            rest = rest / rdx;
            role = roles_q[2*k +: 2];
            role_val[role] = val;
        end
        hue = role_val[ROLE_HUE];
        sat = role_val[ROLE_SAT];
        bri = role_val[ROLE_BRI];
        h3 = 3 * hue;
        if (h3 < ONE)
        begin
            wr = ONE - h3; wg = h3; wb = 0;
        end
        else if (h3 > 2 * ONE)
        begin
            wr = h3 - 2 * ONE; wg = 0; wb = 3 * ONE - h3;
        end
        else
        begin
            wr = 0; wg = 2 * ONE - h3; wb = h3 - ONE;
        end
        res.red   = 8'(channel_to_byte(blend(wr, sat, bri)));
        res.green = 8'(channel_to_byte(blend(wg, sat, bri)));
        res.blue  = 8'(channel_to_byte(blend(wb, sat, bri)));
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin
        rgb_entry_t exp_e;
        if (rst_n && done)
        begin
            n_results++;
            if (expected_rgb.size() == 0)
                report_mismatch("unexpected result, queue size", 1, 0);
            else
            begin
                exp_e = expected_rgb.pop_front();
                if (red !== exp_e.red)
                    report_mismatch("red", red, exp_e.red);
                if (green !== exp_e.green)
                    report_mismatch("green", green, exp_e.green);
                if (blue !== exp_e.blue)
                    report_mismatch("blue", blue, exp_e.blue);
                if (format_error !== exp_e.format_error)
                    report_mismatch("format_error", format_error, exp_e.format_error);
            end
        end
    end

    task automatic hold_off(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic send_item(logic [FIELD_W-1:0] idx);
        @(negedge clk);
        while (busy)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        palette_index <= idx;
        @(posedge clk);
        expected_rgb.push_back(predict_rgb(idx));
        n_items++;
        if (allow_idle && $urandom_range(0, 5) == 0)
            hold_off($urandom_range(1, 5));
    endtask

    task automatic wait_drained();
        hold_off(1);
        wait (expected_rgb.size() == 0);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
        bit rdy;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever
        begin
            #1;
            rdy = cfg_ready;
            @(posedge clk);
            if (rdy)
                break;
            @(negedge clk);
        end
        case (idx)
            CFG_ROLES:    roles_q     = data[ROLES_W-1:0];
            CFG_RADIX_0:  radix_q[0]  = data;
            CFG_RADIX_1:  radix_q[1]  = data;
            CFG_RADIX_2:  radix_q[2]  = data;
            CFG_OFFSET_0: offset_q[0] = data;
            CFG_OFFSET_1: offset_q[1] = data;
            CFG_OFFSET_2: offset_q[2] = data;
            default: ;
        endcase
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [ROLES_W-1:0] roles, logic [FIELD_W-1:0] r0,
                              logic [FIELD_W-1:0] r1, logic [FIELD_W-1:0] r2,
                              logic [FIELD_W-1:0] o0, logic [FIELD_W-1:0] o1,
                              logic [FIELD_W-1:0] o2);
        wait_drained();
        write_reg(CFG_ROLES, {10'h0, roles});
        write_reg(CFG_RADIX_0, r0);
        write_reg(CFG_RADIX_1, r1);
        write_reg(CFG_RADIX_2, r2);
        write_reg(CFG_OFFSET_0, o0);
        write_reg(CFG_OFFSET_1, o1);
        write_reg(CFG_OFFSET_2, o2);
    endtask

    function automatic logic [FIELD_W-1:0] rand_radix();
        case ($urandom_range(0, 9))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            2:       return FIELD_W'($urandom_range(0, 16'hFFFF));
            default: return FIELD_W'($urandom_range(2, 40));
        endcase
    endfunction

    function automatic logic [1:0] rand_role();
        return 2'($urandom_range(0, 2));
    endfunction

    task automatic test_reset_values();
        send_item(16'h0000);
        send_item(16'h0001);
        send_item(16'h000F);
        send_item(16'h0010);
        send_item(16'h003F);
        send_item(16'h00FF);
        send_item(16'h0100);
        send_item(16'hFFFF);
        send_item(16'hAAAA);
        send_item(16'h5555);
    endtask

    task automatic test_roles_offsets();
        // duplicate roles, later digit wins; saturation and brightness unset
        set_config({ROLE_HUE, ROLE_HUE, ROLE_HUE}, 3, 3, 3, 0, 0, 0);
        send_item(16'd5);
        send_item(16'd26);
        // max offsets push sums above one and wrap
        set_config({ROLE_SAT, ROLE_BRI, ROLE_HUE}, 1, 16'hFFFF, 7,
                   16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(16'hFFFF);
        send_item(16'h1234);
        set_config({ROLE_BRI, ROLE_SAT, ROLE_HUE}, 6, 2, 2, 16'h8000, 0, 16'h0001);
        for (int i = 0; i < 6; i++)
            send_item(FIELD_W'(i));
        // unused register index is ignored
        wait_drained();
        write_reg(3'd7, 16'hFFFF);
        send_item(16'd3);
    endtask

    task automatic test_format_errors();
        set_config({ROLE_ILLEGAL, ROLE_SAT, ROLE_HUE}, 4, 4, 4, 0, 0, 0);
        send_item(16'd9);
        set_config({ROLE_BRI, ROLE_ILLEGAL, ROLE_HUE}, 4, 4, 4, 0, 0, 0);
        send_item(16'd9);
        set_config({ROLE_BRI, ROLE_SAT, ROLE_ILLEGAL}, 4, 4, 4, 0, 0, 0);
        send_item(16'd9);
        set_config({ROLE_BRI, ROLE_SAT, ROLE_HUE}, 0, 4, 4, 0, 0, 0);
        send_item(16'd9);
        set_config({ROLE_BRI, ROLE_SAT, ROLE_HUE}, 4, 0, 4, 0, 0, 0);
        send_item(16'd9);
        set_config({ROLE_BRI, ROLE_SAT, ROLE_HUE}, 4, 4, 0, 0, 0, 0);
        send_item(16'hFFFF);
    endtask

    task automatic test_random_phases();
        logic [ROLES_W-1:0] roles;
        for (int ph = 0; ph < 20; ph++)
        begin
            roles = {rand_role(), rand_role(), rand_role()};
            if ($urandom_range(0, 9) == 0)
                roles = ROLES_W'($urandom_range(0, 63));
            set_config(roles, rand_radix(), rand_radix(), rand_radix(),
                       FIELD_W'($urandom_range(0, 16'hFFFF)),
                       FIELD_W'($urandom_range(0, 16'hFFFF)),
                       FIELD_W'($urandom_range(0, 16'hFFFF)));
            allow_idle = (ph < 17);
            for (int i = 0; i < 25; i++)
                send_item($urandom_range(0, 1) ? FIELD_W'($urandom_range(0, 16'hFFFF))
                                               : FIELD_W'($urandom_range(0, 255)));
            if (ph == 8)
            begin
                wait_drained();
                write_reg(3'd7, FIELD_W'($urandom_range(0, 16'hFFFF)));
            end
        end
    endtask

    task automatic test_drain_pause();
        allow_idle = 1'b1;
        for (int i = 0; i < 10; i++)
            send_item(FIELD_W'($urandom_range(0, 16'hFFFF)));
        hold_off(1);
        wait (expected_rgb.size() == 0);
        for (int i = 0; i < 10; i++)
            send_item(FIELD_W'($urandom_range(0, 16'hFFFF)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        palette_index = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        n_errors = 0;
        n_items = 0;
        n_results = 0;
        n_cfg = 0;
        allow_idle = 1'b1;
        roles_q = ROLES_RESET;
        radix_q = '{RADIX_0_RESET, RADIX_1_RESET, RADIX_2_RESET};
        offset_q = '{16'h0, 16'h0, 16'h0};
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_roles_offsets();
        test_format_errors();
        test_drain_pause();
        test_random_phases();

        wait_drained();
        $display("Covered %0d items, %0d results, %0d register writes", n_items,
                 n_results, n_cfg);
        $display("over reset, role, offset, format error and random settings.");
        if (n_errors == 0)
            $display("palette_index_to_rgb_top test passed");
        else
            $display("palette_index_to_rgb_top test failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("palette_index_to_rgb_top test failed");
        $finish;
    end

endmodule
